>>> rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam int CMD_W   = 3;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int RROW_W  = 5;
  localparam int RCOL_W  = 7;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = 16;
  localparam int OROW_W  = 5;
  localparam int OCOL_W  = 7;

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0a;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_CHAR  = 3'd0,
    CMD_CLEAR     = 3'd1,
    CMD_FILL      = 3'd2,
    CMD_SET_COLOR = 3'd3,
    CMD_READ_CELL = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    WR_BLANK = 2'd0,
    WR_CHAR  = 2'd1,
    WR_COPY  = 2'd2
  } wr_sel_e;

  typedef struct packed {
    logic    load_in;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    mem_we;
    wr_sel_e wr_sel;
    logic    wr_at_cursor;
    logic    mem_re;
    logic    rd_cell;
    logic    cur_home;
    logic    cur_step;
    logic    attr_load;
    logic    scr_set;
    logic    cell_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             is_newline;
    logic             scroll_needed;
    logic             cnt_is_last;
    logic             cnt_is_copy_last;
  } dp_status_t;

  typedef struct packed {
    logic [OROW_W-1:0] cursor_row;
    logic [OCOL_W-1:0] cursor_col;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } result_t;

endpackage

>>> rtl/tcw_datapath.sv
module tcw_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcw_pkg::dp_cmd_t            cmd_i,
  input  logic [tcw_pkg::CMD_W-1:0]   in_cmd_i,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char_i,
  input  logic [tcw_pkg::COLOR_W-1:0] in_fg_i,
  input  logic [tcw_pkg::COLOR_W-1:0] in_bg_i,
  input  logic [tcw_pkg::RROW_W-1:0]  in_rrow_i,
  input  logic [tcw_pkg::RCOL_W-1:0]  in_rcol_i,
  output tcw_pkg::dp_status_t         status_o,
  output tcw_pkg::result_t            result_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0]  mem [CELLS];
  logic [CELL_W-1:0]  rd_data_q;

  logic [CMD_W-1:0]   cmd_q;
  logic [CHAR_W-1:0]  char_q;
  logic [COLOR_W-1:0] fg_q, bg_q;
  logic [RROW_W-1:0]  rrow_q;
  logic [RCOL_W-1:0]  rcol_q;

  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ATTR_W-1:0]  attr_q;
  logic [ADDR_W-1:0]  cnt_q;
  logic               scr_q;
  logic [CELL_W-1:0]  cell_q;

  logic               newline;
  logic               line_end;
  logic               in_range;
  logic [ADDR_W-1:0]  cursor_addr;
  logic [ADDR_W-1:0]  read_addr;
  logic [ADDR_W-1:0]  src_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [CELL_W-1:0]  wr_data;

  assign newline  = (char_q == NEWLINE_CHAR);
  assign line_end = newline || (col_q == LAST_COL);
  assign in_range = (32'(rrow_q) < 32'(ROWS)) && (32'(rcol_q) < 32'(COLUMNS));

  assign cursor_addr = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign read_addr   = ADDR_W'(rrow_q) * ADDR_W'(COLUMNS) + ADDR_W'(rcol_q);
  assign src_addr    = cnt_q + ADDR_W'(COLUMNS);

  assign wr_addr = cmd_i.wr_at_cursor ? cursor_addr : cnt_q;
  assign rd_addr = cmd_i.rd_cell ? read_addr : src_addr;

  always_comb begin
    case (cmd_i.wr_sel)
      WR_BLANK: wr_data = {attr_q, BLANK_CHAR};
      WR_CHAR:  wr_data = {attr_q, char_q};
      WR_COPY:  wr_data = rd_data_q;
      default:  wr_data = {attr_q, BLANK_CHAR};
    endcase
  end

  // screen store
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_re && (!cmd_i.rd_cell || in_range)) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // latched input transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q  <= in_cmd_i;
      char_q <= in_char_i;
      fg_q   <= in_fg_i;
      bg_q   <= in_bg_i;
      rrow_q <= in_rrow_i;
      rcol_q <= in_rcol_i;
    end
  end

  // cursor update
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.cur_home) begin
      row_d = '0;
      col_d = '0;
    end else if (cmd_i.cur_step) begin
      if (line_end) begin
        col_d = '0;
        if (row_q != LAST_ROW) begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      attr_q <= RESET_ATTR;
      cnt_q  <= '0;
      scr_q  <= 1'b0;
      cell_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (cmd_i.attr_load) begin
        attr_q <= {bg_q, fg_q};
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + ADDR_W'(1);
      end
      if (cmd_i.load_in) begin
        scr_q  <= 1'b0;
        cell_q <= '0;
      end else begin
        if (cmd_i.scr_set) begin
          scr_q <= 1'b1;
        end
        if (cmd_i.cell_load) begin
          cell_q <= in_range ? rd_data_q : '0;
        end
      end
    end
  end

  assign status_o.cmd              = cmd_q;
  assign status_o.is_newline       = newline;
  assign status_o.scroll_needed    = line_end && (row_q == LAST_ROW);
  assign status_o.cnt_is_last      = (cnt_q == LAST_CELL);
  assign status_o.cnt_is_copy_last = (cnt_q == LAST_COPY);

  assign result_o.cursor_row = OROW_W'(row_q);
  assign result_o.cursor_col = OCOL_W'(col_q);
  assign result_o.cell_value = cell_q;
  assign result_o.scrolled   = scr_q;

endmodule

>>> rtl/tcw_ctrl.sv
module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  output logic                out_load_o,
  input  tcw_pkg::dp_status_t status_i,
  output tcw_pkg::dp_cmd_t    cmd_o
);
  import tcw_pkg::*;

  typedef enum logic [8:0] {
    ST_INIT     = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_DISPATCH = 9'b000000100,
    ST_FILL     = 9'b000001000,
    ST_SCR_RD   = 9'b000010000,
    ST_SCR_WR   = 9'b000100000,
    ST_BLANK    = 9'b001000000,
    ST_READ     = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.wr_sel = WR_BLANK;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.cnt_is_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_DONE;
        case (status_i.cmd)
          CMD_PUT_CHAR: begin
            cmd_o.cur_step = 1'b1;
            if (!status_i.is_newline) begin
              cmd_o.mem_we       = 1'b1;
              cmd_o.wr_sel       = WR_CHAR;
              cmd_o.wr_at_cursor = 1'b1;
            end
            if (status_i.scroll_needed) begin
              cmd_o.scr_set = 1'b1;
              cmd_o.cnt_clr = 1'b1;
              state_d       = ST_SCR_RD;
            end
          end
          CMD_CLEAR: begin
            cmd_o.cur_home = 1'b1;
            cmd_o.cnt_clr  = 1'b1;
            state_d        = ST_FILL;
          end
          CMD_FILL: begin
            cmd_o.attr_load = 1'b1;
            cmd_o.cur_home  = 1'b1;
            cmd_o.cnt_clr   = 1'b1;
            state_d         = ST_FILL;
          end
          CMD_SET_COLOR: begin
            cmd_o.attr_load = 1'b1;
          end
          CMD_READ_CELL: begin
            cmd_o.mem_re  = 1'b1;
            cmd_o.rd_cell = 1'b1;
            state_d       = ST_READ;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_FILL: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.wr_sel  = (status_i.cmd == CMD_FILL) ? WR_CHAR : WR_BLANK;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.cnt_is_last) begin
          state_d = ST_DONE;
        end
      end
      ST_SCR_RD: begin
        cmd_o.mem_re = 1'b1;
        state_d      = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.wr_sel  = WR_COPY;
        cmd_o.cnt_inc = 1'b1;
        state_d       = status_i.cnt_is_copy_last ? ST_BLANK : ST_SCR_RD;
      end
      ST_BLANK: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.cnt_is_last) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        cmd_o.cell_load = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/text_console_writer.sv
// channel  direction  tdata fields (lsb first)
// s_axis   in         cmd[2:0] char_code[10:3] fg_color[14:11] bg_color[18:15]
//                     read_row[23:19] read_col[30:24], bit 31 zero
// m_axis   out        cursor_row[4:0] cursor_col[11:5] cell_value[27:12]
//                     scrolled[28], bits 31:29 zero
//
// one transaction at a time, all through the single screen store
// read_cell adds a read state; clear and fill write every cell; a scroll reads and writes
// each moved cell, then blanks the bottom row
// after reset a clearing pass over every cell runs before s_axis_tready rises
// the result register lets the next transaction in while m_axis is stalled
module text_console_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // cmd, char_code, fg_color, bg_color, read_row, read_col
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // cursor_row, cursor_col, cell_value, scrolled
);
  import tcw_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  result_t    result;
  result_t    out_q;
  logic       out_valid_q;
  logic       out_free;
  logic       out_load;

  assign out_free = !out_valid_q || m_axis_tready;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  tcw_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (dp_cmd),
    .in_cmd_i  (s_axis_tdata[2:0]),
    .in_char_i (s_axis_tdata[10:3]),
    .in_fg_i   (s_axis_tdata[14:11]),
    .in_bg_i   (s_axis_tdata[18:15]),
    .in_rrow_i (s_axis_tdata[23:19]),
    .in_rcol_i (s_axis_tdata[30:24]),
    .status_o  (dp_status),
    .result_o  (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.scrolled, out_q.cell_value,
                          out_q.cursor_col, out_q.cursor_row};

endmodule

>>> verif/tb_text_console_writer.sv
`timescale 1ns / 100ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned TAIL_CYCLES = 4500;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER  = 90;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned DIRECTED_N  = 25;

  localparam logic [CMD_W-1:0] CMD_FIRST_SPARE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LAST_SPARE  = 3'd7;

  typedef enum int unsigned {
    MIX_SCROLL,
    MIX_LONG_LINE,
    MIX_GENERAL
  } mix_e;

  // s_axis tdata layout, msb first
  typedef struct packed {
    logic              pad;
    logic [RCOL_W-1:0] read_col;
    logic [RROW_W-1:0] read_row;
    logic [COLOR_W-1:0] bg_color;
    logic [COLOR_W-1:0] fg_color;
    logic [CHAR_W-1:0] char_code;
    logic [CMD_W-1:0]  cmd;
  } console_cmd_t;

  // m_axis tdata layout, msb first
  typedef struct packed {
    logic [2:0]        pad;
    logic              scrolled;
    logic [CELL_W-1:0] cell_value;
    logic [OCOL_W-1:0] cursor_col;
    logic [OROW_W-1:0] cursor_row;
  } console_rsp_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic [RROW_W-1:0]  read_row;
    logic [RCOL_W-1:0]  read_col;
    bit                 typed;
    logic [OROW_W-1:0]  exp_row;
    logic [OCOL_W-1:0]  exp_col;
    logic [CELL_W-1:0]  exp_cell;
    logic               exp_scrolled;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  // model of the screen, cursor and color
  logic [CELL_W-1:0] screen_model [CELLS];
  int unsigned       model_row;
  int unsigned       model_col;
  logic [ATTR_W-1:0] model_attr;

  console_rsp_t pending_rsp [$];

  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  int unsigned rsp_cnt;
  int unsigned items_sent;
  int unsigned scroll_cnt;
  int unsigned read_cnt;
  int unsigned wipe_cnt;
  bit          steady;
  bit          hold_done;

  directed_row_t directed_tbl [DIRECTED_N] = '{
    // fresh screen, reads in and out of range, spare codes
    '{CMD_READ_CELL,   8'h00, 4'h0, 4'h0, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 16'h0720, 1'b0},
    '{CMD_READ_CELL,   8'h00, 4'h0, 4'h0, 5'd24, 7'd79,  1'b1, 5'd0, 7'd0, 16'h0720, 1'b0},
    '{CMD_READ_CELL,   8'h00, 4'h0, 4'h0, 5'd25, 7'd0,   1'b1, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_READ_CELL,   8'h00, 4'h0, 4'h0, 5'd0,  7'd80,  1'b1, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_READ_CELL,   8'hff, 4'hf, 4'hf, 5'd31, 7'd127, 1'b1, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_LAST_SPARE,  8'hff, 4'hf, 4'hf, 5'd31, 7'd127, 1'b1, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_FIRST_SPARE, 8'h00, 4'h0, 4'h0, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_SET_COLOR,   8'h00, 4'hf, 4'h0, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 16'h0000, 1'b0},
    // character extremes and newline
    '{CMD_PUT_CHAR,    8'h00, 4'h0, 4'h0, 5'd0,  7'd0,   1'b0, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_PUT_CHAR,    8'hff, 4'h0, 4'h0, 5'd0,  7'd0,   1'b0, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_PUT_CHAR, NEWLINE_CHAR, 4'h0, 4'h0, 5'd0, 7'd0, 1'b0, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_READ_CELL,   8'h00, 4'h0, 4'h0, 5'd0,  7'd0,   1'b0, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_READ_CELL,   8'h00, 4'h0, 4'h0, 5'd0,  7'd1,   1'b0, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_SET_COLOR,   8'h00, 4'h0, 4'hf, 5'd0,  7'd0,   1'b1, 5'd1, 7'd0, 16'h0000, 1'b0},
    '{CMD_PUT_CHAR,    8'h41, 4'h0, 4'h0, 5'd0,  7'd0,   1'b0, 5'd0, 7'd0, 16'h0000, 1'b0},
    // fill stores a newline byte as a plain character
    '{CMD_FILL,   NEWLINE_CHAR, 4'ha, 4'h5, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_READ_CELL,   8'h00, 4'h0, 4'h0, 5'd12, 7'd40,  1'b0, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_READ_CELL,   8'h00, 4'h0, 4'h0, 5'd24, 7'd79,  1'b0, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_PUT_CHAR, NEWLINE_CHAR, 4'h0, 4'h0, 5'd0, 7'd0, 1'b0, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_CLEAR,       8'hff, 4'hf, 4'hf, 5'd31, 7'd127, 1'b1, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_READ_CELL,   8'h00, 4'h0, 4'h0, 5'd0,  7'd0,   1'b0, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_FILL,        8'hff, 4'h0, 4'h0, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_SET_COLOR,   8'h00, 4'hf, 4'hf, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_CLEAR,       8'h00, 4'h0, 4'h0, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 16'h0000, 1'b0},
    '{CMD_READ_CELL,   8'h00, 4'h0, 4'h0, 5'd24, 7'd0,   1'b0, 5'd0, 7'd0, 16'h0000, 1'b0}
  };

  text_console_writer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // cmd, char_code, fg_color, bg_color, read_row, read_col
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)   // cursor_row, cursor_col, cell_value, scrolled
  );

  always #5 clk_i = ~clk_i;

  function automatic void wipe_screen(input logic [CELL_W-1:0] value);
    for (int i = 0; i < CELLS; i++) screen_model[i] = value;
  endfunction

  function automatic console_rsp_t console_step(input console_cmd_t item);
    console_rsp_t rsp;
    rsp = '0;
    case (item.cmd)
      CMD_PUT_CHAR: begin
        if (item.char_code == NEWLINE_CHAR) begin
          model_col = 0;
          model_row++;
        end else begin
          screen_model[model_row * COLUMNS + model_col] = {model_attr, item.char_code};
          model_col++;
          if (model_col >= COLUMNS) begin
            model_col = 0;
            model_row++;
          end
        end
        if (model_row >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
          for (int x = 0; x < COLUMNS; x++)
            screen_model[(ROWS - 1) * COLUMNS + x] = {model_attr, BLANK_CHAR};
          model_row = ROWS - 1;
          rsp.scrolled = 1'b1;
          scroll_cnt++;
        end
      end
      CMD_CLEAR: begin
        wipe_screen({model_attr, BLANK_CHAR});
        model_row = 0;
        model_col = 0;
        wipe_cnt++;
      end
      CMD_FILL: begin
        model_attr = {item.bg_color, item.fg_color};
        wipe_screen({model_attr, item.char_code});
        model_row = 0;
        model_col = 0;
        wipe_cnt++;
      end
      CMD_SET_COLOR: model_attr = {item.bg_color, item.fg_color};
      CMD_READ_CELL: begin
        read_cnt++;
        if (item.read_row < ROWS && item.read_col < COLUMNS)
          rsp.cell_value = screen_model[item.read_row * COLUMNS + item.read_col];
      end
      default: ;
    endcase
    rsp.cursor_row = OROW_W'(model_row);
    rsp.cursor_col = OCOL_W'(model_col);
    return rsp;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic console_cmd_t random_command(input mix_e mix);
    console_cmd_t item;
    int unsigned  r;
    item = $urandom;
    item.pad = 1'b0;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_SCROLL:    r = (r < 95) ? 0 : 50;
      MIX_LONG_LINE: r = (r < 95) ? 10 : 50;
      default:       r = (r < 45) ? r / 2 : (r < 70) ? 50 : (r < 82) ? 75 :
                         (r < 88) ? 85 : (r < 94) ? 90 : 99;
    endcase
    // r now selects: <50 put_char, 50 read, 75 color, 85 clear, 90 fill, 99 spare
    if (r < 50) begin
      item.cmd = CMD_PUT_CHAR;
      if ((mix == MIX_SCROLL && $urandom_range(0, 99) < 95) ||
          (mix == MIX_GENERAL && $urandom_range(0, 99) < 25))
        item.char_code = NEWLINE_CHAR;
      else if (item.char_code == NEWLINE_CHAR)
        item.char_code = item.char_code ^ 8'h01;
    end else if (r == 50) begin
      item.cmd = CMD_READ_CELL;
      if ($urandom_range(0, 3) != 0) begin
        item.read_row = RROW_W'($urandom_range(0, ROWS - 1));
        item.read_col = RCOL_W'($urandom_range(0, COLUMNS - 1));
      end
    end else if (r == 75) item.cmd = CMD_SET_COLOR;
    else if (r == 85) item.cmd = CMD_CLEAR;
    else if (r == 90) item.cmd = CMD_FILL;
    else item.cmd = CMD_FIRST_SPARE + CMD_W'($urandom_range(0, CMD_LAST_SPARE - CMD_FIRST_SPARE));
    return item;
  endfunction

  task automatic send_command(input console_cmd_t item, input bit typed,
                              input console_rsp_t typed_rsp);
    console_rsp_t predicted;
    int unsigned  gap;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = console_step(item);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    items_sent++;
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    console_rsp_t got;
    console_rsp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      rsp_cnt++;
      if (pending_rsp.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected transaction: row %0d col %0d cell %h scrolled %b",
                   got.cursor_row, got.cursor_col, got.cell_value, got.scrolled);
      end else begin
        want = pending_rsp.pop_front();
        if (got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col ||
            got.cell_value !== want.cell_value || got.scrolled !== want.scrolled) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display({"mismatch at result %0d: exp row %0d col %0d cell %h scr %b,",
                      " got row %0d col %0d cell %h scr %b"},
                     rsp_cnt, want.cursor_row, want.cursor_col, want.cell_value,
                     want.scrolled, got.cursor_row, got.cursor_col, got.cell_value,
                     got.scrolled);
        end
      end
    end
  end

  // receiver with one long hold-off
  initial begin : drain
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      if (!hold_done && rsp_cnt >= HOLD_AFTER) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_cnt, pending_rsp.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    console_cmd_t item;
    console_rsp_t typed_rsp;
    int unsigned  puts;
    model_attr = RESET_ATTR;
    wipe_screen({RESET_ATTR, BLANK_CHAR});
    model_row = 0;
    model_col = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_tbl[i]) begin
      item = '0;
      item.cmd       = directed_tbl[i].cmd;
      item.char_code = directed_tbl[i].char_code;
      item.fg_color  = directed_tbl[i].fg_color;
      item.bg_color  = directed_tbl[i].bg_color;
      item.read_row  = directed_tbl[i].read_row;
      item.read_col  = directed_tbl[i].read_col;
      typed_rsp = '0;
      typed_rsp.cursor_row = directed_tbl[i].exp_row;
      typed_rsp.cursor_col = directed_tbl[i].exp_col;
      typed_rsp.cell_value = directed_tbl[i].exp_cell;
      typed_rsp.scrolled   = directed_tbl[i].exp_scrolled;
      send_command(item, directed_tbl[i].typed, typed_rsp);
    end

    // newline-heavy text to reach the bottom row and scroll
    repeat (34) send_command(random_command(MIX_SCROLL), 1'b0, '0);

    // one long line to force wrapping at the line end
    puts = 0;
    while (puts < 82) begin
      steady = (puts < 40);
      item = random_command(MIX_LONG_LINE);
      if (item.cmd == CMD_PUT_CHAR) puts++;
      send_command(item, 1'b0, '0);
    end
    steady = 1'b0;

    repeat (12) send_command(random_command(MIX_GENERAL), 1'b0, '0);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("sent %0d commands: %0d scrolls, %0d cell reads, %0d clear or fill passes",
             items_sent, scroll_cnt, read_cnt, wipe_cnt);
    $display("checked %0d results, %0d mismatches", rsp_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
